// ===== hdl/two_opt_move_engine_assert.svh =====
// Assertion macros for the 2-opt move engine checker
`ifndef TWO_OPT_MOVE_ENGINE_ASSERT_SVH
`define TWO_OPT_MOVE_ENGINE_ASSERT_SVH

// consequence in the cycle after the antecedent
`define TOME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("two_opt_move_engine: assertion failed");

// consequence in the same cycle as the antecedent
`define TOME_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("two_opt_move_engine: assertion failed");

`endif

// ===== hdl/twoopt_pkg.sv =====
// Shared types, constants and microcode program of the 2-opt move engine
package twoopt_pkg;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 8;
  localparam int CITY_W  = 8;
  localparam int VALUE_W = 24;
  localparam int DELTA_W = 18;
  localparam int COST_W  = 24;
  localparam int PC_W    = 5;

  localparam int DEF_CITIES    = 256;
  localparam int DEF_DIST_BITS = 16;

  localparam logic [FUNC_W-1:0] FUNC_WR_TOUR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_DIST = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_COST = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_EVAL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_APPLY = 3'd4;

  localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] S_DISP    = 5'd1;
  localparam logic [PC_W-1:0] S_WTOUR   = 5'd2;
  localparam logic [PC_W-1:0] S_WDIST   = 5'd3;
  localparam logic [PC_W-1:0] S_SETC    = 5'd4;
  localparam logic [PC_W-1:0] S_MV0     = 5'd5;
  localparam logic [PC_W-1:0] S_MV1     = 5'd6;
  localparam logic [PC_W-1:0] S_MV2     = 5'd7;
  localparam logic [PC_W-1:0] S_MV3     = 5'd8;
  localparam logic [PC_W-1:0] S_D0      = 5'd9;
  localparam logic [PC_W-1:0] S_D1      = 5'd10;
  localparam logic [PC_W-1:0] S_D2      = 5'd11;
  localparam logic [PC_W-1:0] S_D3      = 5'd12;
  localparam logic [PC_W-1:0] S_D4      = 5'd13;
  localparam logic [PC_W-1:0] S_SAT     = 5'd14;
  localparam logic [PC_W-1:0] S_NEWC    = 5'd15;
  localparam logic [PC_W-1:0] S_LOOP    = 5'd16;
  localparam logic [PC_W-1:0] S_RDHI    = 5'd17;
  localparam logic [PC_W-1:0] S_WRLO    = 5'd18;
  localparam logic [PC_W-1:0] S_WRHI    = 5'd19;
  localparam logic [PC_W-1:0] S_COMMIT  = 5'd20;
  localparam logic [PC_W-1:0] S_EMIT_M  = 5'd21;
  localparam logic [PC_W-1:0] S_EMIT_P  = 5'd22;
  localparam logic [PC_W-1:0] S_EMIT_I  = 5'd23;

  typedef enum logic [2:0] {
    T_A, T_A1, T_B, T_B1, T_LO, T_HI
  } tsel_t;

  typedef enum logic [2:0] {
    C_NONE, C_V1, C_V1N, C_V2, C_V2N, C_TLO
  } tcap_t;

  typedef enum logic [1:0] {
    W_NONE, W_ITEM, W_LO, W_HI
  } twr_t;

  typedef enum logic [1:0] {
    D_V1V2, D_V1NV2N, D_V1V1N, D_V2V2N
  } dsel_t;

  typedef enum logic [1:0] {
    A_HOLD, A_CLR, A_ADD, A_SUB
  } acc_t;

  typedef enum logic [2:0] {
    L_NONE, L_COST, L_DELTA, L_NEWC, L_COMMIT, L_STEP
  } ld_t;

  typedef enum logic [1:0] {
    E_NONE, E_PLAIN, E_INV, E_MOVE
  } emit_t;

  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_START, J_FUNC, J_INVALID, J_EVAL, J_DONE
  } jmp_t;

  typedef struct packed {
    tsel_t           tsel;
    tcap_t           tcap;
    twr_t            twr;
    dsel_t           dsel;
    logic            dwr;
    acc_t            acc;
    ld_t             ld;
    emit_t           emit;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              invalid;
    logic              is_eval;
    logic              more;
  } dp_stat_t;

  localparam ctrl_t CTRL_NOP = '{
    tsel: T_A, tcap: C_NONE, twr: W_NONE, dsel: D_V1V2, dwr: 1'b0,
    acc: A_HOLD, ld: L_NONE, emit: E_NONE, jmp: J_NEXT, target: S_IDLE
  };

  function automatic logic [PC_W-1:0] dispatch(input logic [FUNC_W-1:0] func);
    logic [PC_W-1:0] t;
    unique case (func) inside
      FUNC_WR_TOUR:          t = S_WTOUR;
      FUNC_WR_DIST:          t = S_WDIST;
      FUNC_SET_COST:         t = S_SETC;
      FUNC_EVAL, FUNC_APPLY: t = S_MV0;
      default:               t = S_EMIT_P;
    endcase
    return t;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      S_IDLE:   begin w.jmp = J_START; w.target = S_DISP; end
      S_DISP:   begin w.jmp = J_FUNC; end
      S_WTOUR:  begin w.twr = W_ITEM; w.jmp = J_ALWAYS; w.target = S_EMIT_P; end
      S_WDIST:  begin w.dwr = 1'b1; w.jmp = J_ALWAYS; w.target = S_EMIT_P; end
      S_SETC:   begin w.ld = L_COST; w.jmp = J_ALWAYS; w.target = S_EMIT_P; end
      S_MV0:    begin w.tsel = T_A; w.jmp = J_INVALID; w.target = S_EMIT_I; end
      S_MV1:    begin w.tsel = T_A1; w.tcap = C_V1; end
      S_MV2:    begin w.tsel = T_B; w.tcap = C_V1N; end
      S_MV3:    begin w.tsel = T_B1; w.tcap = C_V2; end
      S_D0:     begin w.tcap = C_V2N; w.acc = A_CLR; w.dsel = D_V1V2; end
      S_D1:     begin w.dsel = D_V1NV2N; w.acc = A_ADD; end
      S_D2:     begin w.dsel = D_V1V1N; w.acc = A_ADD; end
      S_D3:     begin w.dsel = D_V2V2N; w.acc = A_SUB; end
      S_D4:     begin w.acc = A_SUB; end
      S_SAT:    begin w.ld = L_DELTA; end
      S_NEWC:   begin w.ld = L_NEWC; w.jmp = J_EVAL; w.target = S_EMIT_M; end
      S_LOOP:   begin w.tsel = T_LO; w.jmp = J_DONE; w.target = S_COMMIT; end
      S_RDHI:   begin w.tsel = T_HI; w.tcap = C_TLO; end
      S_WRLO:   begin w.twr = W_LO; end
      S_WRHI:   begin
        w.twr = W_HI; w.ld = L_STEP; w.jmp = J_ALWAYS; w.target = S_LOOP;
      end
      S_COMMIT: begin w.ld = L_COMMIT; end
      S_EMIT_M: begin w.emit = E_MOVE; w.jmp = J_ALWAYS; w.target = S_IDLE; end
      S_EMIT_P: begin w.emit = E_PLAIN; w.jmp = J_ALWAYS; w.target = S_IDLE; end
      S_EMIT_I: begin w.emit = E_INV; w.jmp = J_ALWAYS; w.target = S_IDLE; end
      default:  begin w.jmp = J_ALWAYS; w.target = S_IDLE; end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/twoopt_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic
module twoopt_seq
  import twoopt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctrl_t    ctrl,
  output logic     accept,
  output logic     busy
);

  logic [PC_W-1:0] upc;
  logic [PC_W-1:0] upc_next;
  logic [PC_W-1:0] upc_inc;

  assign ctrl    = ucode(upc);
  assign upc_inc = upc + 1'b1;
  assign busy    = (upc != S_IDLE);
  assign accept  = start && !busy;

  always_comb begin
    unique case (ctrl.jmp)
      J_NEXT:    upc_next = upc_inc;
      J_ALWAYS:  upc_next = ctrl.target;
      J_START:   upc_next = start ? ctrl.target : upc;
      J_FUNC:    upc_next = dispatch(stat.func);
      J_INVALID: upc_next = stat.invalid ? ctrl.target : upc_inc;
      J_EVAL:    upc_next = stat.is_eval ? ctrl.target : upc_inc;
      J_DONE:    upc_next = stat.more ? upc_inc : ctrl.target;
      default:   upc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== hdl/twoopt_dp.sv =====
// Datapath: request registers, tour and distance memories, delta and cost arithmetic
module twoopt_dp
  import twoopt_pkg::*;
#(
  parameter int CITIES    = DEF_CITIES,
  parameter int DIST_BITS = DEF_DIST_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  input  logic                       accept,
  input  logic [FUNC_W-1:0]          func,
  input  logic [IDX_W-1:0]           index_a,
  input  logic [IDX_W-1:0]           index_b,
  input  logic [CITY_W-1:0]          city,
  input  logic [VALUE_W-1:0]         value,
  output dp_stat_t                   stat,
  output logic                       done,
  output logic signed [DELTA_W-1:0]  delta,
  output logic [COST_W-1:0]          cost,
  output logic                       status
);

  localparam int CIDX   = $clog2(CITIES);
  localparam int DDEPTH = 1 << (2 * CIDX);
  localparam int AW     = DIST_BITS + 3;
  localparam int SW     = COST_W + 2;

  logic [FUNC_W-1:0]  func_r;
  logic [IDX_W-1:0]   a_r;
  logic [IDX_W-1:0]   b_r;
  logic [CITY_W-1:0]  city_r;
  logic [VALUE_W-1:0] value_r;

  logic [CITY_W-1:0] tour_mem [CITIES];
  logic [DIST_BITS-1:0] dist_mem [DDEPTH];

  logic [CITY_W-1:0] tq;
  logic [CITY_W-1:0] v1, v1n, v2, v2n, tlo;
  logic [DIST_BITS-1:0] dq;
  logic dz;

  logic [CIDX-1:0] lo, hi;
  logic signed [AW-1:0] acc;
  logic signed [DELTA_W-1:0] delta_r;
  logic [COST_W-1:0] newc;
  logic [COST_W-1:0] tour_cost;

  logic a_ok, b_ok;
  logic [CIDX-1:0] pos_a, pos_a1, pos_b, pos_b1;
  logic [CIDX-1:0] tra, twa;
  logic [CITY_W-1:0] twd;
  logic tw_en;
  logic [CITY_W-1:0] from_c, to_c;
  logic rd_zero;
  logic [2*CIDX-1:0] dra, dwa;
  logic signed [AW-1:0] dq_s;
  logic signed [63:0] acc_x;
  logic signed [DELTA_W-1:0] acc_sat;
  logic signed [SW-1:0] csum;
  logic [COST_W-1:0] csat;

  assign a_ok   = 32'(a_r) < 32'(CITIES);
  assign b_ok   = 32'(b_r) < 32'(CITIES);
  assign pos_a  = CIDX'(32'(a_r));
  assign pos_a1 = CIDX'(32'(a_r) + 32'd1);
  assign pos_b  = CIDX'(32'(b_r));
  assign pos_b1 = CIDX'(32'(b_r) + 32'd1);

  assign stat.func    = func_r;
  assign stat.invalid = (a_r >= b_r) || ((32'(b_r) + 32'd1) >= 32'(CITIES));
  assign stat.is_eval = (func_r == FUNC_EVAL);
  assign stat.more    = (lo < hi);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func;
      a_r     <= index_a;
      b_r     <= index_b;
      city_r  <= city;
      value_r <= value;
    end
  end

  always_comb begin
    case (ctrl.tsel)
      T_A:     tra = pos_a;
      T_A1:    tra = pos_a1;
      T_B:     tra = pos_b;
      T_B1:    tra = pos_b1;
      T_LO:    tra = lo;
      T_HI:    tra = hi;
      default: tra = pos_a;
    endcase
  end

  always_comb begin
    tw_en = 1'b0;
    twa   = lo;
    twd   = tq;
    case (ctrl.twr)
      W_ITEM: begin
        tw_en = a_ok;
        twa   = pos_a;
        twd   = city_r;
      end
      W_LO: begin
        tw_en = 1'b1;
        twa   = lo;
        twd   = tq;
      end
      W_HI: begin
        tw_en = 1'b1;
        twa   = hi;
        twd   = tlo;
      end
      default: tw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tour_mem[twa] <= twd;
    end
    tq <= tour_mem[tra];
  end

  always_ff @(posedge clk) begin
    case (ctrl.tcap)
      C_V1:    v1 <= tq;
      C_V1N:   v1n <= tq;
      C_V2:    v2 <= tq;
      C_V2N:   v2n <= tq;
      C_TLO:   tlo <= tq;
      default: tlo <= tlo;
    endcase
  end

  always_comb begin
    case (ctrl.dsel)
      D_V1V2:   begin from_c = v1;  to_c = v2;  end
      D_V1NV2N: begin from_c = v1n; to_c = v2n; end
      D_V1V1N:  begin from_c = v1;  to_c = v1n; end
      D_V2V2N:  begin from_c = v2;  to_c = v2n; end
      default:  begin from_c = v1;  to_c = v2;  end
    endcase
  end

  assign rd_zero = (32'(from_c) >= 32'(CITIES)) || (32'(to_c) >= 32'(CITIES));
  assign dra     = {CIDX'(32'(from_c)), CIDX'(32'(to_c))};
  assign dwa     = {pos_a, pos_b};

  always_ff @(posedge clk) begin
    if (ctrl.dwr && a_ok && b_ok) begin
      dist_mem[dwa] <= DIST_BITS'(32'(value_r));
    end
    dq <= dist_mem[dra];
    dz <= rd_zero;
  end

  assign dq_s = dz ? '0 : AW'({1'b0, dq});

  always_ff @(posedge clk) begin
    case (ctrl.acc)
      A_CLR:   acc <= '0;
      A_ADD:   acc <= acc + dq_s;
      A_SUB:   acc <= acc - dq_s;
      default: acc <= acc;
    endcase
  end

  assign acc_x = {{(64 - AW){acc[AW-1]}}, acc};

  always_comb begin
    if (acc_x > 64'sd131071) begin
      acc_sat = DELTA_W'(18'sh1FFFF);
    end else if (acc_x < -64'sd131072) begin
      acc_sat = DELTA_W'(18'sh20000);
    end else begin
      acc_sat = DELTA_W'(acc_x);
    end
  end

  assign csum = $signed({2'b00, tour_cost}) + SW'(delta_r);

  always_comb begin
    if (csum < 0) begin
      csat = '0;
    end else if (csum > $signed({2'b00, {COST_W{1'b1}}})) begin
      csat = '1;
    end else begin
      csat = COST_W'(csum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tour_cost <= '0;
    end else begin
      case (ctrl.ld)
        L_COST:   tour_cost <= value_r;
        L_COMMIT: tour_cost <= newc;
        default:  tour_cost <= tour_cost;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.ld)
      L_DELTA: delta_r <= acc_sat;
      L_NEWC: begin
        newc <= csat;
        lo   <= pos_a1;
        hi   <= pos_b;
      end
      L_STEP: begin
        lo <= lo + 1'b1;
        hi <= hi - 1'b1;
      end
      default: lo <= lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.emit != E_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.emit)
      E_PLAIN: begin
        delta  <= '0;
        cost   <= tour_cost;
        status <= 1'b0;
      end
      E_INV: begin
        delta  <= '0;
        cost   <= tour_cost;
        status <= 1'b1;
      end
      E_MOVE: begin
        delta  <= delta_r;
        cost   <= newc;
        status <= 1'b0;
      end
      default: status <= status;
    endcase
  end

endmodule

// ===== hdl/two_opt_move_engine.sv =====
// 2-opt move engine top level: microcode sequencer and datapath
// Unused codes, writes and set cost go straight to the result; rejected moves report status.
// Evaluate reads four tour entries and sums four distances; apply then sweeps the one-port
// tour memory, swapping (second - first) / 2 pairs.
// A new request is accepted only while idle; busy drops in the done cycle, results never stall.
// Synchronous reset clears the step counter, strobe and tour cost; stores start undefined.
module two_opt_move_engine
  import twoopt_pkg::*;
#(
  parameter int CITIES    = DEF_CITIES,
  parameter int DIST_BITS = DEF_DIST_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [FUNC_W-1:0]         func,
  input  logic [IDX_W-1:0]          index_a,
  input  logic [IDX_W-1:0]          index_b,
  input  logic [CITY_W-1:0]         city,
  input  logic [VALUE_W-1:0]        value,
  output logic                      done,
  output logic signed [DELTA_W-1:0] delta,
  output logic [COST_W-1:0]         cost,
  output logic                      status
);

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     accept;

  twoopt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .ctrl   (ctrl),
    .accept (accept),
    .busy   (busy)
  );

  twoopt_dp #(
    .CITIES    (CITIES),
    .DIST_BITS (DIST_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .accept  (accept),
    .func    (func),
    .index_a (index_a),
    .index_b (index_b),
    .city    (city),
    .value   (value),
    .stat    (stat),
    .done    (done),
    .delta   (delta),
    .cost    (cost),
    .status  (status)
  );

endmodule

// ===== hdl/twoopt_chk.sv =====
// Port-level checker for the 2-opt move engine and its bind
`include "two_opt_move_engine_assert.svh"

module twoopt_chk
  import twoopt_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic signed [DELTA_W-1:0] delta,
  input logic                      status
);

  `TOME_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TOME_ASSERT_NEXT(a_idle_holds, clk, rst, !start && !busy, !busy)
  `TOME_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `TOME_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `TOME_ASSERT_SAME(a_reject_zero, clk, rst, done && status, delta == '0)

endmodule

bind two_opt_move_engine twoopt_chk u_chk (.*);
